// File: src/sce_pkg.sv
// Shared types, codes and lookup tables for the softmax cross-entropy gradient unit.
`timescale 1ns / 1ps
package sce_pkg;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   localparam logic [7:0] REG_VOCAB = 8'd0;
   localparam logic [7:0] REG_BATCH = 8'd1;

   localparam logic [16:0] LOG2E_Q16 = 17'd94548;
   localparam logic [15:0] LN2_Q16   = 16'd45426;

   typedef struct packed {
      logic        is_drain;
      logic [15:0] logit;
      logic [15:0] target;
      logic        last;
      logic        batch_last;
   } cmd_type;

   // 2^(-i/16) in Q1.15
   function automatic logic [15:0] pow2_val(input logic [4:0] i);
      logic [15:0] v;
      unique case (i)
         5'd0:  v = 16'd32768;
         5'd1:  v = 16'd31379;
         5'd2:  v = 16'd30048;
         5'd3:  v = 16'd28774;
         5'd4:  v = 16'd27554;
         5'd5:  v = 16'd26386;
         5'd6:  v = 16'd25268;
         5'd7:  v = 16'd24196;
         5'd8:  v = 16'd23170;
         5'd9:  v = 16'd22188;
         5'd10: v = 16'd21248;
         5'd11: v = 16'd20347;
         5'd12: v = 16'd19484;
         5'd13: v = 16'd18658;
         5'd14: v = 16'd17867;
         5'd15: v = 16'd17110;
         default: v = 16'd16384;
      endcase
      return v;
   endfunction

   // log2(1+i/16) in Q16
   function automatic logic [16:0] log2_val(input logic [4:0] i);
      logic [16:0] v;
      unique case (i)
         5'd0:  v = 17'd0;
         5'd1:  v = 17'd5732;
         5'd2:  v = 17'd11136;
         5'd3:  v = 17'd16248;
         5'd4:  v = 17'd21098;
         5'd5:  v = 17'd25711;
         5'd6:  v = 17'd30109;
         5'd7:  v = 17'd34312;
         5'd8:  v = 17'd38336;
         5'd9:  v = 17'd42196;
         5'd10: v = 17'd45904;
         5'd11: v = 17'd49472;
         5'd12: v = 17'd52911;
         5'd13: v = 17'd56229;
         5'd14: v = 17'd59434;
         5'd15: v = 17'd62534;
         default: v = 17'd65536;
      endcase
      return v;
   endfunction

endpackage

// File: src/sce_front.sv
// Front end: accepts words, drops those that do not fit the phase, tags row and batch ends.
`timescale 1ns / 1ps
module sce_front #(
   parameter int PW = 17,
   parameter int RW = 9
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  logic [PW-1:0]        n,
   input  logic [RW-1:0]        rows,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_func,
   input  logic [15:0]          req_logit,
   input  logic [15:0]          req_target_index,
   input  logic                 q_full,
   output logic                 q_push,
   output sce_pkg::cmd_type     q_data
);

   logic          drain_ff;
   logic [PW-1:0] load_cnt_ff;
   logic [PW-1:0] drain_cnt_ff;
   logic [RW-1:0] rows_ff;
   logic          accept;
   logic          load_last;
   logic          drain_last;
   logic          batch_end;

   assign req_stall  = q_full;
   assign accept     = req_valid && !req_stall;
   assign load_last  = ((PW+1)'(load_cnt_ff) + (PW+1)'(1)) >= (PW+1)'(n);
   assign drain_last = ((PW+1)'(drain_cnt_ff) + (PW+1)'(1)) >= (PW+1)'(n);
   assign batch_end  = ((RW+1)'(rows_ff) + (RW+1)'(1)) >= (RW+1)'(rows);

   always_comb begin
      q_push = 1'b0;
      q_data.is_drain   = req_func;
      q_data.logit      = req_logit;
      q_data.target     = req_target_index;
      q_data.last       = 1'b0;
      q_data.batch_last = 1'b0;
      if (accept) begin
         if (req_func == sce_pkg::FUNC_LOAD && !drain_ff) begin
            q_push      = 1'b1;
            q_data.last = load_last;
         end else if (req_func == sce_pkg::FUNC_DRAIN && drain_ff) begin
            q_push            = 1'b1;
            q_data.last       = drain_last;
            q_data.batch_last = drain_last && batch_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         drain_ff     <= 1'b0;
         load_cnt_ff  <= '0;
         drain_cnt_ff <= '0;
         rows_ff      <= '0;
      end else if (q_push) begin
         if (!drain_ff) begin
            if (load_last) begin
               load_cnt_ff <= '0;
               drain_ff    <= 1'b1;
            end else begin
               load_cnt_ff <= load_cnt_ff + PW'(1);
            end
         end else begin
            if (drain_last) begin
               drain_cnt_ff <= '0;
               drain_ff     <= 1'b0;
               rows_ff      <= batch_end ? '0 : rows_ff + RW'(1);
            end else begin
               drain_cnt_ff <= drain_cnt_ff + PW'(1);
            end
         end
      end
   end

endmodule

// File: src/sce_fifo.sv
// Four-entry command queue between front and back.
`timescale 1ns / 1ps
module sce_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic             push,
   input  sce_pkg::cmd_type push_data,
   input  logic             pop,
   output sce_pkg::cmd_type pop_data,
   output logic             full,
   output logic             empty,
   output logic [2:0]       count
);

   sce_pkg::cmd_type entry_ff [4];
   logic [1:0] wr_ptr_ff;
   logic [1:0] rd_ptr_ff;
   logic [2:0] count_ff;

   assign full     = (count_ff == 3'd4);
   assign empty    = (count_ff == 3'd0);
   assign count    = count_ff;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push && !full) entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push && !full) wr_ptr_ff <= wr_ptr_ff + 2'd1;
         if (pop && !empty) rd_ptr_ff <= rd_ptr_ff + 2'd1;
         count_ff <= count_ff + 3'((push && !full) ? 1 : 0) - 3'((pop && !empty) ? 1 : 0);
      end
   end

endmodule

// File: src/sce_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module sce_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [46:0] dividend,
   input  logic [31:0] divisor,
   output logic [46:0] quotient,
   output logic        done
);

   logic [46:0] dvd_ff;
   logic [31:0] rem_ff;
   logic [31:0] dsr_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [32:0] trial;
   logic        fits;

   assign trial    = {rem_ff, dvd_ff[46]};
   assign fits     = trial >= {1'b0, dsr_ff};
   assign quotient = dvd_ff;
   assign done     = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == 6'd1);
         if (start) begin
            dvd_ff  <= dividend;
            dsr_ff  <= divisor;
            rem_ff  <= '0;
            cnt_ff  <= 6'd47;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= fits ? 32'(trial - {1'b0, dsr_ff}) : trial[31:0];
            dvd_ff <= {dvd_ff[45:0], fits};
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) busy_ff <= 1'b0;
         end
      end
   end

endmodule

// File: src/sce_back.sv
// Back end: row store, exponential sum, reciprocal, row loss and gradient drain.
`timescale 1ns / 1ps
module sce_back #(
   parameter int MAX_VOCAB = 65536,
   parameter int PW = 17,
   parameter int AW = 16,
   parameter int RW = 9
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  logic [PW-1:0]        n,
   input  logic [RW-1:0]        rows,
   input  logic                 cmd_valid,
   input  sce_pkg::cmd_type     cmd,
   output logic                 cmd_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [15:0]   rsp_gradient,
   output logic                 rsp_row_last,
   output logic                 rsp_batch_last,
   output logic [15:0]          rsp_mean_loss
);

   localparam int TW = PW + 16;

   typedef enum logic [4:0] {
      S_IDLE, S_RD, S_X1, S_X2, S_X3, S_SUM, S_TGT_RD, S_TGT_D, S_INV_WAIT,
      S_NORM, S_LOG1, S_LOG2, S_LOSS, S_G1, S_G2, S_MEAN_WAIT, S_EMIT
   } state_type;

   state_type          state_ff;
   logic signed [15:0] store_mem [MAX_VOCAB];
   logic signed [15:0] rd_data_ff;
   logic signed [15:0] max_ff;
   logic [15:0]        target_ff;
   logic [PW-1:0]      lpos_ff;
   logic [PW-1:0]      dpos_ff;
   logic [PW-1:0]      cnt_ff;
   logic               drain_ff;
   logic               rl_ff;
   logic               bl_ff;
   logic [32:0]        prod_ff;
   logic [8:0]         k_ff;
   logic [15:0]        pi_ff;
   logic [15:0]        interp_ff;
   logic [15:0]        e_ff;
   logic [31:0]        total_ff;
   logic [31:0]        inv_ff;
   logic [31:0]        loss_total_ff;
   logic [15:0]        dt_ff;
   logic [31:0]        sh_ff;
   logic [4:0]         p_ff;
   logic [16:0]        lbase_ff;
   logic [16:0]        lint_ff;
   logic [36:0]        lnp_ff;
   logic [47:0]        gp_ff;
   logic signed [15:0] g_ff;
   logic [15:0]        mean_ff;
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_gradient_ff;
   logic               rsp_row_last_ff;
   logic               rsp_batch_last_ff;
   logic [15:0]        rsp_mean_ff;

   logic               we;
   logic [AW-1:0]      raddr;
   logic [TW-1:0]      tgt_wide;
   logic signed [16:0] diff;
   logic [24:0]        t_val;
   logic [4:0]         tab_i;
   logic [15:0]        p_lo;
   logic [27:0]        interp_prod;
   logic [28:0]        lint_prod;
   logic [20:0]        l2;
   logic [20:0]        ln_val;
   logic [16:0]        loss_sum;
   logic [15:0]        loss;
   logic [48:0]        g_round;
   logic signed [17:0] g_signed;
   logic               tgt_hit;
   logic               tgt_in_row;
   logic               out_free;
   logic               div_start;
   logic [46:0]        div_dividend;
   logic [31:0]        div_divisor;
   logic [46:0]        div_q;
   logic               div_done;

   assign tgt_wide   = TW'(target_ff);
   assign tgt_hit    = TW'(dpos_ff) == tgt_wide;
   assign tgt_in_row = tgt_wide < TW'(n);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign cmd_pop    = (state_ff == S_IDLE) && cmd_valid;
   assign we         = cmd_pop && !cmd.is_drain;
   assign raddr      = (state_ff == S_TGT_RD) ? tgt_wide[AW-1:0] : cnt_ff[AW-1:0];
   assign diff       = 17'(max_ff) - 17'(rd_data_ff);

   assign t_val       = prod_ff[32:8];
   assign tab_i       = {1'b0, t_val[15:12]};
   assign p_lo        = sce_pkg::pow2_val(tab_i + 5'd1);
   assign interp_prod = 28'(sce_pkg::pow2_val(tab_i) - p_lo) * 28'(t_val[11:0]);

   assign lint_prod = 29'(sce_pkg::log2_val({1'b0, sh_ff[30:27]} + 5'd1)
                          - sce_pkg::log2_val({1'b0, sh_ff[30:27]})) * 29'(sh_ff[26:15]);
   assign l2        = {5'(p_ff - 5'd15), 16'd0} + 21'(lbase_ff) + 21'(lint_ff);
   assign ln_val    = lnp_ff[36:16];
   assign loss_sum  = 17'(dt_ff) + 17'((22'(ln_val) + 22'd128) >> 8);
   assign loss      = !tgt_in_row ? 16'hFFFF : (loss_sum[16] ? 16'hFFFF : loss_sum[15:0]);

   assign g_round  = 49'(gp_ff) + 49'(64'd1 << 30);
   assign g_signed = $signed({1'b0, g_round[47:31]}) - (tgt_hit ? 18'sd32768 : 18'sd0);

   assign div_start    = (state_ff == S_TGT_D) || (state_ff == S_G2 && bl_ff);
   assign div_dividend = (state_ff == S_TGT_D) ? (47'd1 << 46)
                         : 47'(loss_total_ff) + 47'(rows >> 1);
   assign div_divisor  = (state_ff == S_TGT_D) ? total_ff : 32'(rows);

   sce_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_q),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (we) store_mem[lpos_ff[AW-1:0]] <= $signed(cmd.logit);
      rd_data_ff <= store_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         state_ff      <= S_IDLE;
         lpos_ff       <= '0;
         dpos_ff       <= '0;
         max_ff        <= 16'sh8000;
         loss_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_EMIT) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  if (!cmd.is_drain) begin
                     if ($signed(cmd.logit) > max_ff) max_ff <= $signed(cmd.logit);
                     target_ff <= cmd.target;
                     lpos_ff   <= lpos_ff + PW'(1);
                     if (cmd.last) begin
                        cnt_ff   <= '0;
                        total_ff <= '0;
                        drain_ff <= 1'b0;
                        state_ff <= S_RD;
                     end
                  end else begin
                     cnt_ff   <= dpos_ff;
                     drain_ff <= 1'b1;
                     rl_ff    <= cmd.last;
                     bl_ff    <= cmd.batch_last;
                     state_ff <= S_RD;
                  end
               end
            end
            S_RD: state_ff <= S_X1;
            S_X1: begin
               prod_ff  <= 33'(diff[15:0]) * 33'(sce_pkg::LOG2E_Q16);
               state_ff <= S_X2;
            end
            S_X2: begin
               k_ff      <= t_val[24:16];
               pi_ff     <= sce_pkg::pow2_val(tab_i);
               interp_ff <= interp_prod[27:12];
               state_ff  <= S_X3;
            end
            S_X3: begin
               e_ff     <= (k_ff > 9'd15) ? 16'd0 : (pi_ff - interp_ff) >> k_ff[3:0];
               state_ff <= drain_ff ? S_G1 : S_SUM;
            end
            S_SUM: begin
               total_ff <= total_ff + 32'(e_ff);
               if ((PW+1)'(cnt_ff) + (PW+1)'(1) >= (PW+1)'(n)) begin
                  state_ff <= S_TGT_RD;
               end else begin
                  cnt_ff   <= cnt_ff + PW'(1);
                  state_ff <= S_RD;
               end
            end
            S_TGT_RD: state_ff <= S_TGT_D;
            S_TGT_D: begin
               dt_ff    <= diff[15:0];
               state_ff <= S_INV_WAIT;
            end
            S_INV_WAIT: begin
               if (div_done) begin
                  inv_ff   <= div_q[31:0];
                  sh_ff    <= total_ff;
                  p_ff     <= 5'd31;
                  state_ff <= S_NORM;
               end
            end
            S_NORM: begin
               if (sh_ff[31]) begin
                  state_ff <= S_LOG1;
               end else begin
                  sh_ff <= sh_ff << 1;
                  p_ff  <= p_ff - 5'd1;
               end
            end
            S_LOG1: begin
               lbase_ff <= sce_pkg::log2_val({1'b0, sh_ff[30:27]});
               lint_ff  <= lint_prod[28:12];
               state_ff <= S_LOG2;
            end
            S_LOG2: begin
               lnp_ff   <= 37'(l2) * 37'(sce_pkg::LN2_Q16);
               state_ff <= S_LOSS;
            end
            S_LOSS: begin
               loss_total_ff <= loss_total_ff + 32'(loss);
               state_ff      <= S_IDLE;
            end
            S_G1: begin
               gp_ff    <= 48'(e_ff) * 48'(inv_ff);
               state_ff <= S_G2;
            end
            S_G2: begin
               if (g_signed > 18'sd32767) g_ff <= 16'sd32767;
               else g_ff <= g_signed[15:0];
               mean_ff  <= '0;
               state_ff <= bl_ff ? S_MEAN_WAIT : S_EMIT;
            end
            S_MEAN_WAIT: begin
               if (div_done) begin
                  mean_ff  <= (div_q > 47'd65535) ? 16'hFFFF : div_q[15:0];
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_gradient_ff   <= g_ff;
                  rsp_row_last_ff   <= rl_ff;
                  rsp_batch_last_ff <= bl_ff;
                  rsp_mean_ff       <= mean_ff;
                  if (rl_ff) begin
                     lpos_ff <= '0;
                     dpos_ff <= '0;
                     max_ff  <= 16'sh8000;
                  end else begin
                     dpos_ff <= dpos_ff + PW'(1);
                  end
                  if (bl_ff) loss_total_ff <= '0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_gradient   = rsp_gradient_ff;
   assign rsp_row_last   = rsp_row_last_ff;
   assign rsp_batch_last = rsp_batch_last_ff;
   assign rsp_mean_loss  = rsp_mean_ff;

endmodule

// File: src/softmax_cross_entropy_grad_unit.sv
// Softmax cross-entropy gradient unit, top level.
// Load word: accepted by the front end into the queue; back end takes one load per cycle while idle.
// Row end: the exponential sum over the logits, then the reciprocal and the log;
// each drain computes one gradient, plus the mean loss division on batch end.
// Reset is synchronous, active high; a write to the vocab or batch register clears the row and batch.
`timescale 1ns / 1ps
module softmax_cross_entropy_grad_unit #(
   parameter int MAX_VOCAB = 65536,
   parameter int MAX_ROWS  = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  logic signed [15:0] req_logit,
   input  logic [15:0]        req_target_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_gradient,
   output logic               rsp_row_last,
   output logic               rsp_batch_last,
   output logic [15:0]        rsp_mean_loss,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [16:0]        csr_data
);

   localparam int PW  = $clog2(MAX_VOCAB + 1);
   localparam int AW  = $clog2(MAX_VOCAB);
   localparam int RW  = $clog2(MAX_ROWS + 1);
   localparam int CW  = (PW > 17) ? PW : 17;
   localparam int RCW = (RW > 9) ? RW : 9;

   logic [16:0]      vocab_ff;
   logic [8:0]       batch_ff;
   logic             clear;
   logic [PW-1:0]    n;
   logic [RW-1:0]    rows;
   logic [CW-1:0]    vocab_w;
   logic [RCW-1:0]   batch_w;
   logic             q_push;
   logic             q_pop;
   logic             q_full;
   logic             q_empty;
   logic [2:0]       q_count;
   sce_pkg::cmd_type q_in;
   sce_pkg::cmd_type q_out;

   assign csr_ready = 1'b1;
   assign clear = csr_valid && csr_ready &&
                  (csr_index == sce_pkg::REG_VOCAB || csr_index == sce_pkg::REG_BATCH);

   always_ff @(posedge clock) begin
      if (reset) begin
         vocab_ff <= 17'd65536;
         batch_ff <= 9'd4;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == sce_pkg::REG_VOCAB) vocab_ff <= csr_data;
         else if (csr_index == sce_pkg::REG_BATCH) batch_ff <= csr_data[8:0];
      end
   end

   assign vocab_w = CW'(vocab_ff);
   assign batch_w = RCW'(batch_ff);

   always_comb begin
      if (vocab_w == '0) n = PW'(1);
      else if (vocab_w > CW'(MAX_VOCAB)) n = PW'(MAX_VOCAB);
      else n = vocab_w[PW-1:0];
      if (batch_w == '0) rows = RW'(1);
      else if (batch_w > RCW'(MAX_ROWS)) rows = RW'(MAX_ROWS);
      else rows = batch_w[RW-1:0];
   end

   sce_front #(.PW(PW), .RW(RW)) u_front (
      .clock            (clock),
      .reset            (reset),
      .clear            (clear),
      .n                (n),
      .rows             (rows),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_logit        (req_logit),
      .req_target_index (req_target_index),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_data           (q_in)
   );

   sce_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .clear     (clear),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .pop_data  (q_out),
      .full      (q_full),
      .empty     (q_empty),
      .count     (q_count)
   );

   sce_back #(.MAX_VOCAB(MAX_VOCAB), .PW(PW), .AW(AW), .RW(RW)) u_back (
      .clock          (clock),
      .reset          (reset),
      .clear          (clear),
      .n              (n),
      .rows           (rows),
      .cmd_valid      (!q_empty),
      .cmd            (q_out),
      .cmd_pop        (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_gradient   (rsp_gradient),
      .rsp_row_last   (rsp_row_last),
      .rsp_batch_last (rsp_batch_last),
      .rsp_mean_loss  (rsp_mean_loss)
   );

   a_batch_in_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_batch_last |-> rsp_row_last)
      else $error("batch end without row end");

   a_mean_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_batch_last |-> rsp_mean_loss == 16'd0)
      else $error("mean loss outside batch end");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_full |-> req_stall && q_count <= 3'd4)
      else $error("command queue overrun");

endmodule
